// ===== sv/rsa_pkg.sv =====
package rsa_pkg;

   // default sizes
   localparam int SLOT_COUNT_DEF  = 32;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int LENGTH_BITS_DEF = 16;

   // fixed port field widths
   localparam int HANDLE_BITS    = 5;
   localparam int OUT_LEN_BITS   = 16;
   localparam int OUT_COUNT_BITS = 16;

   localparam logic [HANDLE_BITS-1:0] NIL_HANDLE = '0;

   // request operations
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_REF   = 2'd1,
      OP_UNREF = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DEAD = 2'd2,
      ST_SAT  = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic exec;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } stat_type;

endpackage

// ===== sv/refcounted_slot_allocator.sv =====
// Reference-counted slot allocator with a FIFO free list. Slot 0 is the
// permanent nil entry; add takes the oldest free slot, drop reference returns
// a slot to the back of the queue when its count reaches zero. After reset the
// block runs a clearing pass through its slot tables with busy high. A request
// is taken when start is high and busy is low; each one first reads the
// single-port slot and queue memories and then updates them, with busy high
// during the update. The response appears on the rsp_ ports with rsp_valid
// high for exactly one cycle, the cycle after the update, and the receiver
// cannot hold it off: it must take it then. A new request may be accepted in
// the same cycle the response is shown, but not while the previous request
// is still being updated.
module refcounted_slot_allocator #(
   parameter int SLOT_COUNT  = rsa_pkg::SLOT_COUNT_DEF,
   parameter int COUNT_BITS  = rsa_pkg::COUNT_BITS_DEF,
   parameter int LENGTH_BITS = rsa_pkg::LENGTH_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_operation,
   input  logic [rsa_pkg::HANDLE_BITS-1:0]     req_handle,
   input  logic [rsa_pkg::OUT_LEN_BITS-1:0]    req_length,
   output logic                                rsp_valid,
   output logic [rsa_pkg::HANDLE_BITS-1:0]     rsp_slot,
   output logic [rsa_pkg::OUT_LEN_BITS-1:0]    rsp_stored_length,
   output logic [rsa_pkg::OUT_COUNT_BITS-1:0]  rsp_count_after,
   output logic                                rsp_released,
   output logic [1:0]                          rsp_status
);
   import rsa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   rsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // slot tables, free queue and response
   rsa_datapath #(
      .SLOT_COUNT  (SLOT_COUNT),
      .COUNT_BITS  (COUNT_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_handle        (req_handle),
      .req_length        (req_length),
      .rsp_valid         (rsp_valid),
      .rsp_slot          (rsp_slot),
      .rsp_stored_length (rsp_stored_length),
      .rsp_count_after   (rsp_count_after),
      .rsp_released      (rsp_released),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== sv/rsa_ctrl.sv =====
module rsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rsa_pkg::stat_type stat,
   output rsa_pkg::cmd_type  cmd,
   output logic              busy
);
   import rsa_pkg::*;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign cmd.clear = (state_ff == S_CLEAR);
   assign cmd.load  = (state_ff == S_IDLE) && start;
   assign cmd.exec  = (state_ff == S_EXEC);
   assign busy      = (state_ff != S_IDLE);

   // checks
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (state_ff == S_IDLE))
      else $error("execute state lasted more than one cycle");

   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && !stat.clear_last) |=> (state_ff == S_CLEAR))
      else $error("clearing pass left early");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

endmodule

// ===== sv/rsa_datapath.sv =====
module rsa_datapath #(
   parameter int SLOT_COUNT  = rsa_pkg::SLOT_COUNT_DEF,
   parameter int COUNT_BITS  = rsa_pkg::COUNT_BITS_DEF,
   parameter int LENGTH_BITS = rsa_pkg::LENGTH_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rsa_pkg::cmd_type                    cmd,
   output rsa_pkg::stat_type                   stat,
   input  logic [1:0]                          req_operation,
   input  logic [rsa_pkg::HANDLE_BITS-1:0]     req_handle,
   input  logic [rsa_pkg::OUT_LEN_BITS-1:0]    req_length,
   output logic                                rsp_valid,
   output logic [rsa_pkg::HANDLE_BITS-1:0]     rsp_slot,
   output logic [rsa_pkg::OUT_LEN_BITS-1:0]    rsp_stored_length,
   output logic [rsa_pkg::OUT_COUNT_BITS-1:0]  rsp_count_after,
   output logic                                rsp_released,
   output logic [1:0]                          rsp_status
);
   import rsa_pkg::*;

   localparam int IDX_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int TOTAL_BITS = IDX_BITS + 1;
   localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(SLOT_COUNT - 1);
   localparam logic [TOTAL_BITS-1:0] FULL_Q    = TOTAL_BITS'(SLOT_COUNT);
   localparam logic [TOTAL_BITS-1:0] INIT_FREE = TOTAL_BITS'(SLOT_COUNT - 1);
   localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

   // storage
   logic [COUNT_BITS-1:0]  count_mem [SLOT_COUNT];
   logic [LENGTH_BITS-1:0] len_mem   [SLOT_COUNT];
   logic [IDX_BITS-1:0]    fq_mem    [SLOT_COUNT];

   // queue and sweep registers
   logic [IDX_BITS-1:0]   head_ff, head_in;
   logic [IDX_BITS-1:0]   tail_ff, tail_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [IDX_BITS-1:0]   clr_ff;

   // captured request and read data
   op_type                 op_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [IDX_BITS-1:0]    idx_ff;
   logic [LENGTH_BITS-1:0] len_ff;
   logic                   range_ff;
   logic [COUNT_BITS-1:0]  cnt_rd_ff;
   logic [LENGTH_BITS-1:0] len_rd_ff;
   logic [IDX_BITS-1:0]    fq_rd_ff;

   // response registers
   logic                      valid_ff;
   logic [HANDLE_BITS-1:0]    slot_ff;
   logic [OUT_LEN_BITS-1:0]   olen_ff;
   logic [OUT_COUNT_BITS-1:0] ocnt_ff;
   logic                      rel_ff;
   status_type                st_ff;

   // request decode
   logic [31:0]            handle_wide;
   logic [31:0]            length_wide;
   logic [IDX_BITS-1:0]    req_addr;
   logic                   req_range;
   logic [LENGTH_BITS-1:0] req_len;

   assign handle_wide = 32'(req_handle);
   assign length_wide = 32'(req_length);
   assign req_addr    = handle_wide[IDX_BITS-1:0];
   assign req_range   = (handle_wide >= 32'(SLOT_COUNT));
   assign req_len     = length_wide[LENGTH_BITS-1:0];

   // sweep counter for the clearing pass
   assign stat.clear_last = (clr_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear && !stat.clear_last) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(req_operation);
         handle_ff <= req_handle;
         idx_ff    <= req_addr;
         len_ff    <= req_len;
         range_ff  <= req_range;
      end
   end

   // execute logic
   logic                   cnt_we, len_we, fq_we;
   logic [IDX_BITS-1:0]    cnt_wa, len_wa;
   logic [COUNT_BITS-1:0]  cnt_wd;
   logic [LENGTH_BITS-1:0] len_wd;
   logic [HANDLE_BITS-1:0] res_slot;
   logic [LENGTH_BITS-1:0] res_len;
   logic [COUNT_BITS-1:0]  res_cnt;
   logic                   res_rel;
   status_type             res_st;
   logic [31:0]            fq_wide;

   assign fq_wide = 32'(fq_rd_ff);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      total_in = total_ff;
      cnt_we   = 1'b0;
      len_we   = 1'b0;
      fq_we    = 1'b0;
      cnt_wa   = idx_ff;
      len_wa   = idx_ff;
      cnt_wd   = cnt_rd_ff;
      len_wd   = '0;
      res_slot = handle_ff;
      res_len  = '0;
      res_cnt  = '0;
      res_rel  = 1'b0;
      res_st   = ST_OK;
      if (op_ff == OP_ADD) begin
         if (total_ff == '0) begin
            res_slot = '0;
            res_st   = ST_FULL;
         end else begin
            head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
            total_in = total_ff - 1'b1;
            cnt_we   = 1'b1;
            cnt_wa   = fq_rd_ff;
            cnt_wd   = CNT_ONE;
            len_we   = 1'b1;
            len_wa   = fq_rd_ff;
            len_wd   = len_ff;
            res_slot = fq_wide[HANDLE_BITS-1:0];
            res_len  = len_ff;
            res_cnt  = CNT_ONE;
         end
      end else if (range_ff) begin
         res_st = ST_DEAD;
      end else if (op_ff == OP_QUERY || handle_ff == NIL_HANDLE) begin
         res_len = len_rd_ff;
         res_cnt = cnt_rd_ff;
      end else if (cnt_rd_ff == '0) begin
         res_st  = ST_DEAD;
         res_len = len_rd_ff;
      end else if (op_ff == OP_REF) begin
         res_len = len_rd_ff;
         if (cnt_rd_ff == '1) begin
            res_st  = ST_SAT;
            res_cnt = cnt_rd_ff;
         end else begin
            cnt_we  = 1'b1;
            cnt_wd  = cnt_rd_ff + 1'b1;
            res_cnt = cnt_wd;
         end
      end else begin
         // drop reference, free the slot at zero
         cnt_we  = 1'b1;
         cnt_wd  = cnt_rd_ff - 1'b1;
         res_cnt = cnt_wd;
         res_len = len_rd_ff;
         if (cnt_rd_ff == CNT_ONE) begin
            len_we  = 1'b1;
            res_len = '0;
            res_rel = 1'b1;
            if (total_ff < FULL_Q) begin
               fq_we    = 1'b1;
               tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
               total_in = total_ff + 1'b1;
            end
         end
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= LAST_IDX;
         total_ff <= INIT_FREE;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         total_ff <= total_in;
      end
   end

   // count memory
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         count_mem[clr_ff] <= (clr_ff == '0) ? CNT_ONE : '0;
      end else if (cmd.exec && cnt_we) begin
         count_mem[cnt_wa] <= cnt_wd;
      end
      if (cmd.load) begin
         cnt_rd_ff <= count_mem[req_addr];
      end
   end

   // length memory
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         len_mem[clr_ff] <= '0;
      end else if (cmd.exec && len_we) begin
         len_mem[len_wa] <= len_wd;
      end
      if (cmd.load) begin
         len_rd_ff <= len_mem[req_addr];
      end
   end

   // free queue memory
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         fq_mem[clr_ff] <= stat.clear_last ? '0 : clr_ff + 1'b1;
      end else if (cmd.exec && fq_we) begin
         fq_mem[tail_ff] <= idx_ff;
      end
      if (cmd.load) begin
         fq_rd_ff <= fq_mem[head_ff];
      end
   end

   // response
   logic [31:0] res_len_wide;
   logic [31:0] res_cnt_wide;

   assign res_len_wide = 32'(res_len);
   assign res_cnt_wide = 32'(res_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         slot_ff <= res_slot;
         olen_ff <= res_len_wide[OUT_LEN_BITS-1:0];
         ocnt_ff <= res_cnt_wide[OUT_COUNT_BITS-1:0];
         rel_ff  <= res_rel;
         st_ff   <= res_st;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_stored_length = olen_ff;
   assign rsp_count_after   = ocnt_ff;
   assign rsp_released      = rel_ff;
   assign rsp_status        = st_ff;

   // checks
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= INIT_FREE)
      else $error("free queue holds more slots than exist beside nil");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff)
      else $error("response strobe lasted more than one cycle");

   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rel_ff) |-> (st_ff == ST_OK && ocnt_ff == '0))
      else $error("release reported with nonzero count or error status");

endmodule
